/* rtl/tce_pkg.sv */
// Shared constants and codes for the touch calibrate event unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tce_pkg;

  localparam int ADC_BITS_DEF   = 10;
  localparam int PIXEL_BITS_DEF = 12;

  // Configuration register index space.
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_OFFSET   = 3'd0,
    REG_X_SPAN     = 3'd1,
    REG_Y_OFFSET   = 3'd2,
    REG_Y_SPAN     = 3'd3,
    REG_X_RES      = 3'd4,
    REG_Y_RES      = 3'd5,
    REG_REVERSE    = 3'd6,
    REG_THRESHOLD  = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    OP_POLL = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  // Reset values of the configuration registers.
  localparam int X_OFFSET_RST  = 75;
  localparam int X_SPAN_RST    = 955;
  localparam int Y_OFFSET_RST  = 75;
  localparam int Y_SPAN_RST    = 955;
  localparam int X_RES_RST     = 320;
  localparam int Y_RES_RST     = 240;
  localparam int REVERSE_RST   = 0;
  localparam int THRESHOLD_RST = 512;

endpackage

`default_nettype wire

/* rtl/tce_stream_if.sv */
// Valid/ready channel interfaces for the sample input and the event output.
// Depends on tce_pkg for the default field widths.
`default_nettype none

interface tce_in_if
  import tce_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                opcode;
  logic                pen_up_pin;
  logic [ADC_BITS-1:0] press_level;
  logic [ADC_BITS-1:0] raw_x;
  logic [ADC_BITS-1:0] raw_y;

  modport source (
    output valid, opcode, pen_up_pin, press_level, raw_x, raw_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, pen_up_pin, press_level, raw_x, raw_y,
    output ready
  );
endinterface

interface tce_out_if
  import tce_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  event_valid;
  logic [PIXEL_BITS-1:0] event_x;
  logic [PIXEL_BITS-1:0] event_y;
  logic                  event_pressed;
  logic                  event_waiting;

  modport source (
    output valid, event_valid, event_x, event_y, event_pressed, event_waiting,
    input  ready
  );
  modport sink (
    input  valid, event_valid, event_x, event_y, event_pressed, event_waiting,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/tce_axis_lane.sv */
// One calibration axis: clamp, bit-serial shift-add multiply by the resolution,
// bit-serial restoring divide by the span, then limit and mirror. Uses tce_pkg.
`default_nettype none

module tce_axis_lane
  import tce_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ADC_BITS-1:0]   raw_i,
  input  wire logic [ADC_BITS-1:0]   off_i,
  input  wire logic [ADC_BITS:0]     span_i,
  input  wire logic [PIXEL_BITS-1:0] res_i,
  input  wire logic                  mirror_i,
  output logic                       done_o,
  output logic [PIXEL_BITS-1:0]      value_o
);

  localparam int W        = ADC_BITS + PIXEL_BITS;
  localparam int CNT_BITS = $clog2(W);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_FIN  = 4'b1000
  } lane_state_e;

  lane_state_e           state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [ADC_BITS-1:0]   mcand_q, mcand_d;
  logic [PIXEL_BITS-1:0] mplier_q, mplier_d;
  logic [W-1:0]          acc_q, acc_d;
  logic [ADC_BITS:0]     rem_q, rem_d;
  logic [PIXEL_BITS-1:0] value_q, value_d;

  logic [ADC_BITS+1:0]   trial;
  logic [ADC_BITS+1:0]   diff;
  logic                  sub_ok;
  logic                  sat;
  logic [PIXEL_BITS-1:0] lim;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    value_d  = value_q;

    // The remainder stays below the span, so one more bit always fits.
    trial  = {rem_q, acc_q[W-1]};
    sub_ok = trial >= {1'b0, span_i};
    diff   = trial - {1'b0, span_i};

    sat = (span_i == '0) || (acc_q >= {{ADC_BITS{1'b0}}, res_i});
    lim = sat ? res_i : acc_q[PIXEL_BITS-1:0];

    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          mcand_d  = (raw_i < off_i) ? '0 : raw_i - off_i;
          mplier_d = res_i;
          acc_d    = '0;
          cnt_d    = CNT_BITS'(PIXEL_BITS - 1);
          state_d  = L_MUL;
        end
      end
      L_MUL: begin
        // Multiplier bits are taken MSB first.
        acc_d    = {acc_q[W-2:0], 1'b0} +
                   (mplier_q[PIXEL_BITS-1] ? {{PIXEL_BITS{1'b0}}, mcand_q} : '0);
        mplier_d = {mplier_q[PIXEL_BITS-2:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = CNT_BITS'(W - 1);
          rem_d   = '0;
          state_d = L_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      L_DIV: begin
        // The dividend shifts out of the top as quotient bits shift in below.
        rem_d = sub_ok ? diff[ADC_BITS:0] : trial[ADC_BITS:0];
        acc_d = {acc_q[W-2:0], sub_ok};
        if (cnt_q == '0) begin
          state_d = L_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      L_FIN: begin
        value_d = mirror_i ? res_i - lim : lim;
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    value_q  <= value_d;
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

/* rtl/touch_calibrate_event_unit.sv */
// Touch calibrate event unit: one word in, one result word out per input word.
// A pressed poll runs through the bit-serial multiply and divide in each axis lane before
// its result is loaded into the output register; reads and release polls skip the lanes.
// One word is in work at a time; the next is accepted the cycle after a result is loaded,
// even while it waits. Asynchronous active-low reset restores the register defaults and
// clears the control, touch and output-valid state; the output data fields are not reset.
`default_nettype none

module touch_calibrate_event_unit
  import tce_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [((ADC_BITS + 1 > PIXEL_BITS) ? ADC_BITS + 1 : PIXEL_BITS)-1:0]
                                       cfg_data_i,
  tce_in_if.sink                       in_i,
  tce_out_if.source                    out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Configuration registers.
  logic [ADC_BITS-1:0]   x_off_q, y_off_q, thr_q;
  logic [ADC_BITS:0]     x_span_q, y_span_q;
  logic [PIXEL_BITS-1:0] x_res_q, y_res_q;
  logic [1:0]            rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q  <= ADC_BITS'(X_OFFSET_RST);
      x_span_q <= (ADC_BITS + 1)'(X_SPAN_RST);
      y_off_q  <= ADC_BITS'(Y_OFFSET_RST);
      y_span_q <= (ADC_BITS + 1)'(Y_SPAN_RST);
      x_res_q  <= PIXEL_BITS'(X_RES_RST);
      y_res_q  <= PIXEL_BITS'(Y_RES_RST);
      rev_q    <= 2'(REVERSE_RST);
      thr_q    <= ADC_BITS'(THRESHOLD_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_OFFSET:  x_off_q  <= cfg_data_i[ADC_BITS-1:0];
        REG_X_SPAN:    x_span_q <= cfg_data_i[ADC_BITS:0];
        REG_Y_OFFSET:  y_off_q  <= cfg_data_i[ADC_BITS-1:0];
        REG_Y_SPAN:    y_span_q <= cfg_data_i[ADC_BITS:0];
        REG_X_RES:     x_res_q  <= cfg_data_i[PIXEL_BITS-1:0];
        REG_Y_RES:     y_res_q  <= cfg_data_i[PIXEL_BITS-1:0];
        REG_REVERSE:   rev_q    <= cfg_data_i[1:0];
        REG_THRESHOLD: thr_q    <= cfg_data_i[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Control and touch state.
  state_e                state_q, state_d;
  logic                  op_q, op_d;
  logic                  press_q, press_d;
  logic                  pressed_q, pressed_d;
  logic                  pend_q, pend_d;
  logic [PIXEL_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [PIXEL_BITS-1:0] rep_x_q, rep_x_d, rep_y_q, rep_y_d;

  // Output register.
  logic                  ovld_q, ovld_d;
  logic                  oev_q, oev_d;
  logic [PIXEL_BITS-1:0] ox_q, ox_d, oy_q, oy_d;
  logic                  op_pr_q, op_pr_d;
  logic                  owait_q, owait_d;

  logic                  accept;
  logic                  start;
  logic                  slot_free;
  logic                  x_done;
  logic                  y_done;
  logic [PIXEL_BITS-1:0] x_val, y_val;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign start      = accept && (opcode_e'(in_i.opcode) == OP_POLL) &&
                      !in_i.pen_up_pin && !(in_i.press_level > thr_q);
  assign slot_free  = !ovld_q || out_o.ready;

  tce_axis_lane #(
    .ADC_BITS   (ADC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .raw_i    (in_i.raw_x),
    .off_i    (x_off_q),
    .span_i   (x_span_q),
    .res_i    (x_res_q),
    .mirror_i (rev_q[0]),
    .done_o   (x_done),
    .value_o  (x_val)
  );

  tce_axis_lane #(
    .ADC_BITS   (ADC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .raw_i    (in_i.raw_y),
    .off_i    (y_off_q),
    .span_i   (y_span_q),
    .res_i    (y_res_q),
    .mirror_i (rev_q[1]),
    .done_o   (y_done),
    .value_o  (y_val)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    press_d   = press_q;
    pressed_d = pressed_q;
    pend_d    = pend_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    rep_x_d   = rep_x_q;
    rep_y_d   = rep_y_q;
    ovld_d    = ovld_q && !out_o.ready;
    oev_d     = oev_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    op_pr_d   = op_pr_q;
    owait_d   = owait_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = in_i.opcode;
          press_d = start;
          state_d = start ? ST_CALC : ST_EMIT;
        end
      end
      ST_CALC: begin
        // Both lanes run in lockstep, so they finish together.
        if (x_done && y_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          oev_d   = 1'b0;
          ox_d    = '0;
          oy_d    = '0;
          op_pr_d = 1'b0;
          if (opcode_e'(op_q) == OP_POLL) begin
            if (press_q) begin
              cur_x_d   = x_val;
              cur_y_d   = y_val;
              pend_d    = pend_q || (x_val != rep_x_q) || (y_val != rep_y_q) ||
                          !pressed_q;
              pressed_d = 1'b1;
            end else begin
              pend_d    = pend_q || pressed_q;
              pressed_d = 1'b0;
            end
          end else if (pend_q) begin
            oev_d   = 1'b1;
            ox_d    = cur_x_q;
            oy_d    = cur_y_q;
            op_pr_d = pressed_q;
            rep_x_d = cur_x_q;
            rep_y_d = cur_y_q;
            pend_d  = 1'b0;
          end
          owait_d = pend_d;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= 1'b0;
      press_q   <= 1'b0;
      pressed_q <= 1'b0;
      pend_q    <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      rep_x_q   <= '0;
      rep_y_q   <= '0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      press_q   <= press_d;
      pressed_q <= pressed_d;
      pend_q    <= pend_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      rep_x_q   <= rep_x_d;
      rep_y_q   <= rep_y_d;
      ovld_q    <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oev_q   <= oev_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    op_pr_q <= op_pr_d;
    owait_q <= owait_d;
  end

  assign out_o.valid         = ovld_q;
  assign out_o.event_valid   = oev_q;
  assign out_o.event_x       = ox_q;
  assign out_o.event_y       = oy_q;
  assign out_o.event_pressed = op_pr_q;
  assign out_o.event_waiting = owait_q;

endmodule

`default_nettype wire

/* bench/tb_touch_calibrate_event_unit.sv */
`timescale 1ns / 100ps
// Self-checking bench for touch_calibrate_event_unit: a directed table, then random samples
// over several calibration settings, each result checked against the table or a touch tracker.
// Depends on tce_pkg, the tce_in_if / tce_out_if interfaces and the unit itself.

module tb_touch_calibrate_event_unit;
  import tce_pkg::*;

  localparam int ADC_W   = ADC_BITS_DEF;
  localparam int PIX_W   = PIXEL_BITS_DEF;
  localparam int CFG_W   = (ADC_W + 1 > PIX_W) ? ADC_W + 1 : PIX_W;
  localparam int ADC_MAX = (1 << ADC_W) - 1;
  localparam int CFG_MAX = (1 << CFG_W) - 1;

  localparam int RANDOM_PER_SETTING = 183;
  localparam int LONG_HOLD          = 300;
  localparam int SETTLE_CYCLES      = 40;
  localparam int STALL_LIMIT        = 5000;
  localparam int N_DIRECTED         = 20;

  typedef struct packed {
    opcode_e          op;
    logic             pen_up;
    logic [ADC_W-1:0] level;
    logic [ADC_W-1:0] raw_x;
    logic [ADC_W-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             pressed;
    logic             waiting;
  } touch_event_t;

  typedef struct packed {
    sample_t      s;
    logic         typed;
    touch_event_t ev;
  } dir_row_t;

  localparam touch_event_t QUIET   = '0;
  localparam touch_event_t WAITING = '{1'b0, 12'd0, 12'd0, 1'b0, 1'b1};

  // Rows with typed = 0 are checked against the tracker only.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b1, QUIET},
    '{'{OP_POLL, 1'b1, 10'd0,    10'd0,    10'd0   }, 1'b1, QUIET},
    '{'{OP_POLL, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b1, QUIET},
    '{'{OP_POLL, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b1, WAITING},
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b1, '{1'b1, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{'{OP_POLL, 1'b0, 10'd512,  10'd75,   10'd75  }, 1'b1, QUIET},
    '{'{OP_READ, 1'b1, 10'd1023, 10'd1023, 10'd1023}, 1'b1, QUIET},
    '{'{OP_POLL, 1'b0, 10'd0,    10'd1023, 10'd1023}, 1'b0, QUIET},
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b0, QUIET},
    '{'{OP_POLL, 1'b1, 10'd1023, 10'd0,    10'd0   }, 1'b1, WAITING},
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b0, QUIET},
    '{'{OP_POLL, 1'b0, 10'd513,  10'd500,  10'd500 }, 1'b1, QUIET},
    '{'{OP_POLL, 1'b0, 10'd0,    10'h2AA,  10'h155 }, 1'b0, QUIET},
    '{'{OP_POLL, 1'b0, 10'd0,    10'h155,  10'h2AA }, 1'b0, QUIET},
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b0, QUIET},
    '{'{OP_POLL, 1'b0, 10'd0,    10'h155,  10'h2AA }, 1'b1, QUIET},
    '{'{OP_POLL, 1'b0, 10'd0,    10'd1023, 10'd0   }, 1'b0, QUIET},
    '{'{OP_POLL, 1'b1, 10'd0,    10'd1023, 10'd0   }, 1'b1, WAITING},
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b0, QUIET},
    '{'{OP_READ, 1'b0, 10'd0,    10'd0,    10'd0   }, 1'b1, QUIET}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;

  tce_in_if  sample_if ();
  tce_out_if event_if ();

  touch_calibrate_event_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (sample_if),
    .out_o      (event_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Calibration registers as the unit should hold them.
  logic [ADC_W-1:0] cal_x_origin = ADC_W'(X_OFFSET_RST);
  logic [ADC_W:0]   cal_x_span   = (ADC_W + 1)'(X_SPAN_RST);
  logic [ADC_W-1:0] cal_y_origin = ADC_W'(Y_OFFSET_RST);
  logic [ADC_W:0]   cal_y_span   = (ADC_W + 1)'(Y_SPAN_RST);
  logic [PIX_W-1:0] cal_x_res    = PIX_W'(X_RES_RST);
  logic [PIX_W-1:0] cal_y_res    = PIX_W'(Y_RES_RST);
  logic [1:0]       cal_rev      = 2'(REVERSE_RST);
  logic [ADC_W-1:0] cal_thresh   = ADC_W'(THRESHOLD_RST);

  // Touch tracking state.
  logic [PIX_W-1:0] cur_x = '0, cur_y = '0, shown_x = '0, shown_y = '0;
  logic             pen_down = 1'b0, event_pending = 1'b0;
  logic [ADC_W-1:0] last_raw_x = '0, last_raw_y = '0;

  touch_event_t awaited_events [$];

  int  tx_idle_pct, rx_idle_pct;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;
  int  n_faults = 0;
  int  n_samples = 0, n_settings = 1;
  int  n_press_polls = 0, n_release_polls = 0, n_handed = 0, n_empty_reads = 0;

  function automatic logic [PIX_W-1:0] scale_axis(input logic [ADC_W-1:0] raw,
                                                  input logic [ADC_W-1:0] off,
                                                  input logic [ADC_W:0]   span,
                                                  input logic [PIX_W-1:0] res,
                                                  input logic             mirror);
    int unsigned r, o, sp, rs, v;
    r  = 32'(raw);
    o  = 32'(off);
    sp = 32'(span);
    rs = 32'(res);
    if (r < o) r = o;
    // A zero span saturates the divider to the full resolution.
    if (sp == 0) v = rs;
    else v = ((r - o) * rs) / sp;
    if (v >= rs) v = rs;
    if (mirror) v = rs - v;
    return PIX_W'(v);
  endfunction

  function automatic touch_event_t track_touch(input sample_t s);
    touch_event_t ev;
    ev = '0;
    if (s.op == OP_POLL) begin
      if (s.pen_up || s.level > cal_thresh) begin
        if (pen_down) event_pending = 1'b1;
        pen_down = 1'b0;
        n_release_polls++;
      end else begin
        cur_x = scale_axis(s.raw_x, cal_x_origin, cal_x_span, cal_x_res, cal_rev[0]);
        cur_y = scale_axis(s.raw_y, cal_y_origin, cal_y_span, cal_y_res, cal_rev[1]);
        if (cur_x != shown_x || cur_y != shown_y || !pen_down) event_pending = 1'b1;
        pen_down = 1'b1;
        n_press_polls++;
      end
    end else if (event_pending) begin
      ev.valid      = 1'b1;
      ev.x          = cur_x;
      ev.y          = cur_y;
      ev.pressed    = pen_down;
      event_pending = 1'b0;
      shown_x       = cur_x;
      shown_y       = cur_y;
      n_handed++;
    end else begin
      n_empty_reads++;
    end
    ev.waiting = event_pending;
    return ev;
  endfunction

  // Mostly well-formed touch traffic: presses that hold still or move, releases and reads.
  function automatic sample_t next_sample();
    sample_t s;
    int      pick;
    s.op     = OP_POLL;
    s.pen_up = 1'b0;
    s.level  = ADC_W'($urandom_range(ADC_MAX));
    s.raw_x  = ADC_W'($urandom_range(ADC_MAX));
    s.raw_y  = ADC_W'($urandom_range(ADC_MAX));
    pick = $urandom_range(99);
    if (pick < 35) begin
      s.op     = OP_READ;
      s.pen_up = 1'($urandom_range(1));
    end else if (pick < 55) begin
      if (cal_thresh == ADC_MAX || $urandom_range(1) == 1) s.pen_up = 1'b1;
      else s.level = ADC_W'($urandom_range(ADC_MAX, int'(cal_thresh) + 1));
    end else begin
      s.level = ADC_W'($urandom_range(int'(cal_thresh)));
      pick = $urandom_range(99);
      if (pick < 25) begin
        s.raw_x = last_raw_x;
        s.raw_y = last_raw_y;
      end else if (pick < 40) begin
        s.raw_x = ($urandom_range(1) == 1) ? ADC_W'($urandom_range(int'(cal_x_origin)))
                                           : ADC_W'(ADC_MAX - $urandom_range(7));
        s.raw_y = ($urandom_range(1) == 1) ? ADC_W'($urandom_range(int'(cal_y_origin)))
                                           : ADC_W'(ADC_MAX - $urandom_range(7));
      end
      last_raw_x = s.raw_x;
      last_raw_y = s.raw_y;
    end
    return s;
  endfunction

  function automatic int sender_gap();
    int n;
    n = 0;
    while (n < 16 && $urandom_range(99) < tx_idle_pct) n++;
    return n;
  endfunction

  task automatic push_sample(input sample_t s, input logic typed, input touch_event_t typed_ev);
    int           gap;
    touch_event_t predicted;
    gap = sender_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.valid       <= 1'b1;
    sample_if.opcode      <= s.op;
    sample_if.pen_up_pin  <= s.pen_up;
    sample_if.press_level <= s.level;
    sample_if.raw_x       <= s.raw_x;
    sample_if.raw_y       <= s.raw_y;
    @(posedge clk_i);
    while (sample_if.ready !== 1'b1) @(posedge clk_i);
    predicted = track_touch(s);
    awaited_events.push_back(typed ? typed_ev : predicted);
    n_samples++;
  endtask

  // Stop offering words and wait until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input int hold_at, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain_results();
      push_sample(next_sample(), 1'b0, QUIET);
    end
    drain_results();
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    logic [CFG_W-1:0] data;
    data = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_X_OFFSET:  cal_x_origin = data[ADC_W-1:0];
      REG_X_SPAN:    cal_x_span   = data[ADC_W:0];
      REG_Y_OFFSET:  cal_y_origin = data[ADC_W-1:0];
      REG_Y_SPAN:    cal_y_span   = data[ADC_W:0];
      REG_X_RES:     cal_x_res    = data[PIX_W-1:0];
      REG_Y_RES:     cal_y_res    = data[PIX_W-1:0];
      REG_REVERSE:   cal_rev      = data[1:0];
      REG_THRESHOLD: cal_thresh   = data[ADC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned x_off, input int unsigned x_span,
                              input int unsigned y_off, input int unsigned y_span,
                              input int unsigned x_res, input int unsigned y_res,
                              input int unsigned rev, input int unsigned thresh);
    write_reg(REG_X_OFFSET, x_off);
    write_reg(REG_X_SPAN, x_span);
    write_reg(REG_Y_OFFSET, y_off);
    write_reg(REG_Y_SPAN, y_span);
    write_reg(REG_X_RES, x_res);
    write_reg(REG_Y_RES, y_res);
    write_reg(REG_REVERSE, rev);
    write_reg(REG_THRESHOLD, thresh);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_faults++;
    end
  endtask

  // Receiver: random ready, or one long hold-off on request so the unit backs up.
  initial begin
    event_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        event_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        event_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    touch_event_t want;
    if (rst_ni && event_if.valid === 1'b1 && event_if.ready === 1'b1) begin
      if (awaited_events.size() == 0) begin
        $error("result word arrived with no sample outstanding");
        n_faults++;
      end else begin
        want = awaited_events.pop_front();
        check_field("event_valid", PIX_W'(want.valid), PIX_W'(event_if.event_valid));
        check_field("event_x", want.x, event_if.event_x);
        check_field("event_y", want.y, event_if.event_y);
        check_field("event_pressed", PIX_W'(want.pressed), PIX_W'(event_if.event_pressed));
        check_field("event_waiting", PIX_W'(want.waiting), PIX_W'(event_if.event_waiting));
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) || (event_if.valid && event_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_events.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = REG_X_OFFSET;
    cfg_data_i            = '0;
    sample_if.valid       = 1'b0;
    sample_if.opcode      = OP_POLL;
    sample_if.pen_up_pin  = 1'b0;
    sample_if.press_level = '0;
    sample_if.raw_x       = '0;
    sample_if.raw_y       = '0;
    tx_idle_pct           = 38;
    rx_idle_pct           = 75;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      push_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].ev);
    run_random(RANDOM_PER_SETTING, -1, -1);

    // Widest span and resolution, both axes mirrored, release only by the pin.
    program_regs(0, 1024, 0, 1024, 4095, 4095, 3, 1023);
    run_random(RANDOM_PER_SETTING, 60, -1);

    tx_idle_pct = 75;
    rx_idle_pct = 38;
    // Narrowest settings: every position collapses to one pixel.
    program_regs(ADC_MAX, 1, ADC_MAX, 1, 1, 1, 0, 0);
    run_random(RANDOM_PER_SETTING, -1, -1);

    // Zero X span, zero Y resolution with Y mirrored, and upper bits that must be masked.
    program_regs('hC4B, 0, 'h800, 'h805, 640, 0, 'hFFE, 'hDFF);
    run_random(RANDOM_PER_SETTING, -1, -1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs($urandom_range(ADC_MAX), $urandom_range(ADC_MAX + 1, 1),
                 $urandom_range(ADC_MAX), $urandom_range(ADC_MAX + 1, 1),
                 $urandom_range(4095, 1), $urandom_range(4095, 1),
                 $urandom_range(3), $urandom_range(ADC_MAX));
    run_random(RANDOM_PER_SETTING, -1, -1);

    program_regs($urandom_range(CFG_MAX), $urandom_range(CFG_MAX), $urandom_range(CFG_MAX),
                 $urandom_range(CFG_MAX), $urandom_range(CFG_MAX), $urandom_range(CFG_MAX),
                 $urandom_range(CFG_MAX), $urandom_range(CFG_MAX));
    run_random(RANDOM_PER_SETTING, -1, -1);

    program_regs(X_OFFSET_RST, X_SPAN_RST, Y_OFFSET_RST, Y_SPAN_RST,
                 X_RES_RST, Y_RES_RST, REVERSE_RST, THRESHOLD_RST);
    run_random(RANDOM_PER_SETTING, -1, 90);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d sample words over %0d calibration settings: %0d pressed, %0d released.",
             n_samples, n_settings, n_press_polls, n_release_polls);
    $display("Reads handed out %0d events and found nothing pending %0d times; %0d failures.",
             n_handed, n_empty_reads, n_faults);
    if (n_faults == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
